// ----- sv/ira_pkg.sv -----
package ira_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;

  localparam int RADIX_W = 5;
  localparam int REM_W   = 4;
  localparam int CHAR_W  = 7;
  localparam int OUT_TDATA_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_A = 7'd55;  // 'A' minus ten
  localparam logic [REM_W-1:0]  DEC_MAX       = 4'd9;

  // controller -> datapath
  typedef struct packed {
    logic start;  // load number, clear digit count
    logic step;   // one restoring-division bit
    logic push;   // store remainder as next digit
    logic rd;     // fetch top digit into the output register
    logic pop;    // digit taken downstream
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bits_done;
    logic quo_zero;
    logic count_one;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [REM_W-1:0] r);
    logic [CHAR_W-1:0] r_ext;
    r_ext = {{(CHAR_W-REM_W){1'b0}}, r};
    if (r <= DEC_MAX) begin
      digit_ascii = r_ext + ASCII_ZERO;
    end else begin
      digit_ascii = r_ext + ASCII_ALPHA_A;
    end
  endfunction

endpackage

// ----- sv/integer_to_radix_ascii.sv -----
// Radix converter: each number transferred in is written out as ASCII digits
// ('0'-'9', 'A'-'F') in the base held by the radix register, most significant
// digit first, one transfer per digit, with tlast on the final digit; zero
// gives a single '0'. The radix resets to 10, and a write of a value outside
// 2..16 is dropped. Write it only while the block is idle. One number is
// handled at a time: s_tready is high only between numbers. Each digit takes
// a full pass of the divider (one quotient bit per cycle) and is pushed onto
// the digit stack; the digits are then read from the stack into the output
// register one at a time, each held until it is taken downstream.
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = ira_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // number in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,   // [VALUE_BITS-1:0] number
  // digits out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ira_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [6:0] digit_char
  output logic                               m_tlast,   // last_digit
  // radix register
  input  logic                               cfg_wen,
  input  logic [ira_pkg::RADIX_W-1:0]        cfg_wdata
);
  import ira_pkg::*;

  cmd_t                cmd;
  status_t             status;
  logic [CHAR_W-1:0]   digit_char;

  // controller: handshakes and sequencing of divide / push / read
  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: radix register, serial divider, digit stack, output register
  ira_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .number     (s_tdata[VALUE_BITS-1:0]),  // padding bits ignored
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .digit_char (digit_char),
    .last_digit (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, digit_char};

endmodule

// ----- sv/ira_dp.sv -----
module ira_dp #(
  parameter int VALUE_BITS = ira_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ira_pkg::cmd_t                 cmd,
  output ira_pkg::status_t              status,
  input  logic [VALUE_BITS-1:0]         number,
  input  logic                          cfg_wen,
  input  logic [ira_pkg::RADIX_W-1:0]   cfg_wdata,
  output logic [ira_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last_digit
);
  import ira_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int AW = $clog2(VALUE_BITS);
  localparam int BW = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] quo;
  logic [REM_W-1:0]      rem;
  logic [BW-1:0]         bitcnt;
  logic [CW-1:0]         count;
  logic [REM_W-1:0]      mem [VALUE_BITS];

  logic [RADIX_W-1:0]    trial;
  logic                  ge;
  logic [RADIX_W-1:0]    diff;
  logic [REM_W-1:0]      rem_next;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;

  // restoring division, one quotient bit per cycle; remainder stays below 16
  assign trial    = {rem, quo[VALUE_BITS-1]};
  assign ge       = (trial >= radix);
  assign diff     = trial - radix;
  assign rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

  assign cnt_m1  = count - CW'(1);
  assign rd_addr = cnt_m1[AW-1:0];
  assign wr_addr = count[AW-1:0];

  assign status.bits_done = (bitcnt == BW'(VALUE_BITS - 1));
  assign status.quo_zero  = (quo == '0);
  assign status.count_one = (count == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      radix  <= RADIX_RESET;
      count  <= '0;
      bitcnt <= '0;
    end else begin
      if (cfg_wen && cfg_wdata >= RADIX_MIN && cfg_wdata <= RADIX_MAX) begin
        radix <= cfg_wdata;
      end
      if (cmd.start) begin
        count  <= '0;
        bitcnt <= '0;
      end else if (cmd.step) begin
        bitcnt <= bitcnt + BW'(1);
      end else if (cmd.push) begin
        count  <= count + CW'(1);
        bitcnt <= '0;
      end else if (cmd.pop) begin
        count <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo <= number;
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[VALUE_BITS-2:0], ge};
      rem <= rem_next;
    end else if (cmd.push) begin
      rem <= '0;
    end
  end

  // digit stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      digit_char <= digit_ascii(mem[rd_addr]);
      last_digit <= status.count_one;
    end
  end

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    radix >= RADIX_MIN && radix <= RADIX_MAX)
    else $error("radix register out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < CW'(VALUE_BITS))
    else $error("digit stack overflow");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.pop) |-> count != '0)
    else $error("digit stack read while empty");

  a_step_after_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.bits_done) |=> bitcnt == '0 || cmd.push)
    else $error("division ran past its last bit");

endmodule

// ----- sv/ira_ctrl.sv -----
module ira_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ira_pkg::status_t  status,
  output ira_pkg::cmd_t     cmd
);
  import ira_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    PUSH,
    READ,
    SHOW
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.step = 1'b1;
        if (status.bits_done) begin
          state_next = PUSH;
        end
      end
      PUSH: begin
        cmd.push   = 1'b1;
        state_next = status.quo_zero ? READ : DIV;
      end
      READ: begin
        cmd.rd     = 1'b1;
        state_next = SHOW;
      end
      SHOW: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.pop    = 1'b1;
          state_next = status.count_one ? IDLE : READ;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- tb/radix_digit_checker.sv -----
`timescale 1ns / 100ps

module radix_digit_checker
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,   // [VALUE_BITS-1:0] number
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [OUT_TDATA_W-1:0]          m_tdata,   // [6:0] digit_char
  input  logic                            m_tlast,   // last_digit
  input  logic                            cfg_wen,
  input  logic [RADIX_W-1:0]              cfg_wdata,
  output int                              fail_count,
  output int                              digits_due_count,
  output int                              numbers_seen,
  output int                              digits_seen
);

  localparam int DECIMAL_DIGITS = 10;
  localparam logic [CHAR_W-1:0] CHR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHR_A    = 7'h41;  // 'A'

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic [RADIX_W-1:0] base;
  digit_t             digits_due[$];

  // Split a number into its digits in the given base, most significant first.
  task automatic expand_to_digits(input logic [VALUE_BITS-1:0] value,
                                  input logic [RADIX_W-1:0] rdx);
    logic [VALUE_BITS-1:0] rest;
    logic [VALUE_BITS-1:0] r;
    logic [REM_W-1:0]      rems[$];
    digit_t                d;
    rest = value;
    // do-while: zero still yields one '0'
    do begin
      r = rest % rdx;
      rems.push_front(r[REM_W-1:0]);
      rest = rest / rdx;
    end while (rest != 0);
    foreach (rems[i]) begin
      if (rems[i] < DECIMAL_DIGITS) begin
        d.ch = CHR_ZERO + rems[i];
      end else begin
        d.ch = CHR_A + (rems[i] - DECIMAL_DIGITS);
      end
      d.last = (i == rems.size() - 1);
      digits_due.push_back(d);
    end
  endtask

  always @(posedge clk) begin : watch
    digit_t want;
    if (rst) begin
      base = RADIX_RESET;
      digits_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        digits_seen++;
        if (digits_due.size() == 0) begin
          fail_count++;
          $error("digit transfer with none expected: digit_char %0d, last_digit %0b",
                 m_tdata[CHAR_W-1:0], m_tlast);
        end else begin
          want = digits_due.pop_front();
          if (m_tdata[CHAR_W-1:0] !== want.ch) begin
            fail_count++;
            $error("digit_char: expected %0d, got %0d", want.ch, m_tdata[CHAR_W-1:0]);
          end
          if (m_tlast !== want.last) begin
            fail_count++;
            $error("last_digit: expected %0b, got %0b", want.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        numbers_seen++;
        expand_to_digits(s_tdata[VALUE_BITS-1:0], base);  // pad bits ignored
      end
      // out-of-range bases are dropped by the register
      if (cfg_wen && cfg_wdata >= RADIX_MIN && cfg_wdata <= RADIX_MAX) begin
        base = cfg_wdata;
      end
    end
    digits_due_count = digits_due.size();
  end

endmodule

// ----- tb/integer_to_radix_ascii_tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the radix converter. The checker beside the DUT
// does all prediction and comparison; this module only drives the number
// stream, the digit-side tready and the radix register.
module integer_to_radix_ascii_tb;
  import ira_pkg::*;

  localparam int VALUE_BITS      = DEFAULT_VALUE_BITS;
  localparam int S_TDATA_W       = ((VALUE_BITS+7)/8)*8;
  localparam int RANDOM_ITEMS    = 90;
  localparam int ITEMS_PER_PHASE = 10;
  localparam int MAX_GAP         = 19;
  localparam int LONG_HOLD       = 300;   // receiver stall, long enough to back up the input
  localparam int HOLD_AT_DIGIT   = 150;
  localparam int DRAIN_CYCLES    = VALUE_BITS + 8;  // about one digit's divider pass
  localparam logic [VALUE_BITS-1:0] NUMBER_MAX = '1;
  localparam logic [RADIX_W-1:0]    RADIX_TOP  = '1;  // largest value the port can carry

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;    // [VALUE_BITS-1:0] number
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [6:0] digit_char
  logic                  m_tlast;    // last_digit
  logic                  cfg_wen;
  logic [RADIX_W-1:0]    cfg_wdata;

  int fail_count;
  int digits_due_count;
  int numbers_seen;
  int digits_seen;
  int digits_taken;
  int radix_writes;
  int radix_drops;
  bit tx_idle_on;
  bit rx_idle_on;

  integer_to_radix_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  radix_digit_checker #(.VALUE_BITS(VALUE_BITS)) digit_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .digits_due_count (digits_due_count),
    .numbers_seen     (numbers_seen),
    .digits_seen      (digits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one number; called and returns at a falling edge. tvalid stays
  // high on return so back-to-back numbers need no extra assignment.
  task automatic send_number(input logic [S_TDATA_W-1:0] word);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Radix writes only once every outstanding digit has come out; cfg_wen drops
  // again with an idle gap after each write, keeping consecutive writes apart.
  task automatic write_radix(input logic [RADIX_W-1:0] value);
    s_tvalid <= 1'b0;
    while (digits_due_count != 0) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    radix_writes++;
    if (value < RADIX_MIN || value > RADIX_MAX) begin
      radix_drops++;
    end
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Random bit widths mix short and long numbers; zero and the maximum turn up often.
  function automatic logic [VALUE_BITS-1:0] draw_number();
    int          w;
    logic [63:0] raw;
    case ($urandom_range(0, 9))
      0: draw_number = '0;
      1: draw_number = NUMBER_MAX;
      default: begin
        w = $urandom_range(1, VALUE_BITS);
        raw = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        draw_number = raw[VALUE_BITS-1:0];
      end
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] draw_bad_radix();
    if ($urandom_range(0, 1)) begin
      draw_bad_radix = RADIX_W'($urandom_range(0, RADIX_MIN - 1));
    end else begin
      draw_bad_radix = RADIX_W'($urandom_range(RADIX_MAX + 1, RADIX_TOP));
    end
  endfunction

  // Digit side: random tready gaps, none in some phases, and one long
  // hold so that the converter fills and stalls the number stream.
  initial begin : digit_sink
    int gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (digits_taken == HOLD_AT_DIGIT) begin
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      digits_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [RADIX_W-1:0] rdx;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset base of ten, extremes, digit-count edges
    send_number('0);
    send_number(S_TDATA_W'(1));
    send_number(S_TDATA_W'(9));
    send_number(S_TDATA_W'(10));
    send_number(S_TDATA_W'(NUMBER_MAX));
    send_number({1'b1, (S_TDATA_W-1)'(5)});   // pad bit above the number is ignored
    send_number(S_TDATA_W'(1234567890));
    send_number(S_TDATA_W'(100));

    // hex: letters A-F, full-width value
    write_radix(RADIX_MAX);
    send_number(S_TDATA_W'(15));
    send_number(S_TDATA_W'(NUMBER_MAX));
    send_number(S_TDATA_W'(32'h00AB_CDEF));
    send_number(S_TDATA_W'(255));
    send_number('0);

    // binary: longest digit runs
    write_radix(RADIX_MIN);
    send_number('0);
    send_number(S_TDATA_W'(1));
    send_number(S_TDATA_W'(NUMBER_MAX));
    send_number(S_TDATA_W'(32'h2AAA_AAAA));

    // out-of-range bases must leave binary in place
    write_radix('0);
    write_radix(RADIX_MIN - 5'd1);
    write_radix(RADIX_MAX + 5'd1);
    write_radix(RADIX_TOP);
    send_number(S_TDATA_W'(5));

    write_radix(RADIX_MIN + 5'd1);
    send_number(S_TDATA_W'(NUMBER_MAX));
    send_number(S_TDATA_W'(1));

    // Random phases, one base each; three phases in every four drop the gaps on
    // one or both sides so full-rate transfers are exercised too.
    for (int p = 0; p < RANDOM_ITEMS / ITEMS_PER_PHASE; p++) begin
      case (p)
        0:       rdx = RADIX_MIN;
        1:       rdx = RADIX_MAX;
        2:       rdx = RADIX_RESET;
        default: rdx = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_radix(draw_bad_radix());
      end
      write_radix(rdx);
      tx_idle_on = (p % 4 != 1) && (p % 4 != 3);
      rx_idle_on = (p % 4 != 2) && (p % 4 != 3);
      repeat (ITEMS_PER_PHASE) send_number(S_TDATA_W'(draw_number()));
    end

    s_tvalid <= 1'b0;
    while (digits_due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d numbers into %0d digits, bases 2 to 16 incl. the reset base.",
             numbers_seen, digits_seen);
    $display("Radix writes: %0d, of which %0d out of range; one %0d-cycle output stall.",
             radix_writes, radix_drops, LONG_HOLD);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
